FILE: design/tccw_pkg.sv
// Package with the shared screen geometry, codes and types of the text console cursor writer.
`timescale 1ns / 1ps

package tccw_pkg;

  // Screen geometry in character cells.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // Widths that follow from the geometry.
  localparam int COL_W = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int POS_W = 16;
  localparam int OFF_W = 12;

  // Geometry as bytes, for compares against 8-bit targets.
  localparam logic [7:0] COLUMNS_B = 8'(COLUMNS);
  localparam logic [7:0] ROWS_B    = 8'(ROWS);

  // Operation codes of the input channel.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  // Result kinds and port selects.
  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_PORT = 1'b1;
  localparam logic PORT_CMD  = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // Character and cursor port command codes.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CMD_HIGH     = 8'd14;
  localparam logic [7:0] CMD_LOW      = 8'd15;

  // One finished item, handed from the cursor stage to the beat emitter.
  typedef struct packed {
    logic             has_cell;
    logic [OFF_W-1:0] cell_offset;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [POS_W-1:0] pos;
  } tccw_job_t;

endpackage

FILE: design/tccw_cursor.sv
// Input register, cursor state and the single-pass cursor update of the console writer.
`timescale 1ns / 1ps

module tccw_cursor import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_foreground,
  input  logic [7:0] in_background,
  input  logic [7:0] in_target_column,
  input  logic [7:0] in_target_row,
  input  logic       job_ready,
  output logic       job_load,
  output tccw_job_t  job
);

  // Input register.
  logic       valid_r;
  logic       op_r;
  logic [7:0] char_r;
  logic [3:0] fg_r;
  logic [3:0] bg_r;
  logic [7:0] tcol_r;
  logic [7:0] trow_r;

  // Cursor state.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_nxt;

  logic             drop;
  logic             advance;
  logic             in_accept;
  logic             is_newline;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] row_wrap;
  logic [POS_W-1:0] old_pos;
  logic [POS_W-1:0] new_pos;

  // A move whose target lies off the screen is consumed without any result.
  assign drop      = (op_r == OP_MOVE) &&
                     ((tcol_r >= COLUMNS_B) || (trow_r >= ROWS_B));
  assign advance   = valid_r && (drop || job_ready);
  assign job_load  = valid_r && !drop && job_ready;
  assign in_stall  = valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign is_newline = (char_r == CHAR_NEWLINE);
  assign col_inc    = {1'b0, col_r} + 1'b1;
  assign row_inc    = {1'b0, row_r} + 1'b1;
  assign row_wrap   = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];

  // Next cursor position for each kind of item.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (op_r == OP_MOVE) begin
      col_nxt = tcol_r[COL_W-1:0];
      row_nxt = trow_r[ROW_W-1:0];
    end else if (is_newline || (col_inc >= (COL_W+1)'(COLUMNS))) begin
      col_nxt = '0;
      row_nxt = row_wrap;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  // Linear positions before and after the item.
  assign old_pos = POS_W'(row_r) * POS_W'(COLUMNS) + POS_W'(col_r);
  assign new_pos = POS_W'(row_nxt) * POS_W'(COLUMNS) + POS_W'(col_nxt);

  // Job handed to the emitter.
  always_comb begin
    job.has_cell    = (op_r == OP_PUT) && !is_newline;
    job.cell_offset = OFF_W'({old_pos, 1'b0});
    job.cell_char   = char_r;
    job.cell_attr   = {bg_r, fg_r};
    job.pos         = new_pos;
  end

  // Input register and cursor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (in_accept) begin
        valid_r <= 1'b1;
      end else if (advance) begin
        valid_r <= 1'b0;
      end
      if (job_load) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
    if (in_accept) begin
      op_r   <= in_operation;
      char_r <= in_char_code;
      fg_r   <= in_foreground[3:0];
      bg_r   <= in_background[3:0];
      tcol_r <= in_target_column;
      trow_r <= in_target_row;
    end
  end

endmodule

FILE: design/tccw_emit.sv
// Result register and beat sequencer: an optional cell write, then four port writes per job.
`timescale 1ns / 1ps

module tccw_emit import tccw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_load,
  input  tccw_job_t        job,
  output logic             job_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [OFF_W-1:0] out_cell_offset,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic             out_port_is_data,
  output logic [7:0]       out_port_byte,
  output logic             out_last
);

  typedef enum logic [2:0] {
    BEAT_CELL,
    BEAT_CMD_HI,
    BEAT_DATA_HI,
    BEAT_CMD_LO,
    BEAT_DATA_LO
  } beat_t;

  logic      valid_r;
  beat_t     beat_r;
  tccw_job_t job_r;
  logic      fire;

  assign fire      = valid_r && !out_stall;
  assign job_ready = !valid_r || (fire && (beat_r == BEAT_DATA_LO));
  assign out_valid = valid_r;

  // Beat contents; fields unused by a beat read as zero.
  always_comb begin
    out_kind         = KIND_PORT;
    out_cell_offset  = '0;
    out_cell_char    = '0;
    out_cell_attr    = '0;
    out_port_is_data = PORT_CMD;
    out_port_byte    = '0;
    out_last         = 1'b0;
    unique case (beat_r)
      BEAT_CELL: begin
        out_kind        = KIND_CELL;
        out_cell_offset = job_r.cell_offset;
        out_cell_char   = job_r.cell_char;
        out_cell_attr   = job_r.cell_attr;
      end
      BEAT_CMD_HI: begin
        out_port_byte = CMD_HIGH;
      end
      BEAT_DATA_HI: begin
        out_port_is_data = PORT_DATA;
        out_port_byte    = job_r.pos[15:8];
      end
      BEAT_CMD_LO: begin
        out_port_byte = CMD_LOW;
      end
      BEAT_DATA_LO: begin
        out_port_is_data = PORT_DATA;
        out_port_byte    = job_r.pos[7:0];
        out_last         = 1'b1;
      end
      default: begin
        out_kind = KIND_PORT;
      end
    endcase
  end

  // Sequencer state and the held job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_CMD_HI;
    end else if (job_load) begin
      valid_r <= 1'b1;
      beat_r  <= job.has_cell ? BEAT_CELL : BEAT_CMD_HI;
    end else if (fire) begin
      unique case (beat_r)
        BEAT_CELL:    beat_r <= BEAT_CMD_HI;
        BEAT_CMD_HI:  beat_r <= BEAT_DATA_HI;
        BEAT_DATA_HI: beat_r <= BEAT_CMD_LO;
        BEAT_CMD_LO:  beat_r <= BEAT_DATA_LO;
        BEAT_DATA_LO: valid_r <= 1'b0;
        default:      valid_r <= 1'b0;
      endcase
    end
    if (job_load) begin
      job_r <= job;
    end
  end

endmodule

FILE: design/text_console_cursor_writer_top.sv
// Top level of the text console cursor writer.
//
// The input channel takes one item per beat: a put of a character at the
// cursor, or a move of the cursor to a target cell. Both channels use valid
// and stall; a beat passes when valid is high and stall is low.
// A put of a character other than newline gives five result beats: one
// screen cell write and then four cursor port writes (command 14, high
// position byte, command 15, low position byte). A newline or an on-screen
// move gives the four port writes only. A move off the screen gives no
// result at all. The last beat of each item carries out_last. The first beat
// leaves the result register after the item has passed the input register.
// An item holds the result register while it sends its beats, and the
// result port sends one beat per cycle while the receiver does not stall.
// The next item waits in the input register while the current one is still
// sending, so the input side never idles for a full item.
// Reset clears the cursor to column 0, row 0 and empties both registers.
// When the receiver stalls, the current result beat holds and the input
// register stalls once it is full.
`timescale 1ns / 1ps

module text_console_cursor_writer_top import tccw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  logic [7:0]       in_char_code,
  input  logic [7:0]       in_foreground,
  input  logic [7:0]       in_background,
  input  logic [7:0]       in_target_column,
  input  logic [7:0]       in_target_row,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [OFF_W-1:0] out_cell_offset,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic             out_port_is_data,
  output logic [7:0]       out_port_byte,
  output logic             out_last
);

  logic      job_ready;
  logic      job_load;
  tccw_job_t job;

  // Cursor state and per-item update.
  tccw_cursor u_cursor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_foreground    (in_foreground),
    .in_background    (in_background),
    .in_target_column (in_target_column),
    .in_target_row    (in_target_row),
    .job_ready        (job_ready),
    .job_load         (job_load),
    .job              (job)
  );

  // Result beat sequencer.
  tccw_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_load         (job_load),
    .job              (job),
    .job_ready        (job_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_cell_offset  (out_cell_offset),
    .out_cell_char    (out_cell_char),
    .out_cell_attr    (out_cell_attr),
    .out_port_is_data (out_port_is_data),
    .out_port_byte    (out_port_byte),
    .out_last         (out_last)
  );

endmodule
